// File: rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg - shared types and helpers for the URI percent decoder
// Word layouts of both channels, held-state codes, the hex digit and the
// safe-character classification functions.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] PCT_CHAR       = 8'h25;  // '%'
  localparam logic [7:0] HEX_LOWER_BIAS = 8'h57;  // 'a' - 10
  localparam logic [7:0] HEX_UPPER_BIAS = 8'h37;  // 'A' - 10

  // Escape state: nothing held, a '%' held, a '%' and one digit held
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_PCT  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;
  localparam logic [1:0] HELD_RSVD = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;
  } out_word_t;

  // Non-hex bytes count as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - HEX_LOWER_BIAS;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - HEX_UPPER_BIAS;
      end
      return d[3:0];
    end
  endfunction

  // ASCII letters, digits and ! # $ % & ' ( ) * + , - . / : ; = ? @ [ ] _ ~
  function automatic logic is_safe(input logic [7:0] c);
    logic ok;
    begin
      ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
           (c >= 8'h41 && c <= 8'h5a);
      case (c)
        8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
        8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h3a, 8'h3b,
        8'h3d, 8'h3f, 8'h40, 8'h5b, 8'h5d, 8'h5f, 8'h7e: begin
          ok = 1'b1;
        end
        default: begin
        end
      endcase
      return ok;
    end
  endfunction

endpackage

// File: rtl/upd_stream_if.sv
// ----------------------------------------------------------------------------
// upd_stream_if - valid/ready stream channel
// Carries one word per handshake; the word type is set per instance.
// ----------------------------------------------------------------------------
interface upd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/uri_percent_decoder_safe.sv
// ----------------------------------------------------------------------------
// uri_percent_decoder_safe - streaming percent-decoder for URI text
// Decodes %XY escapes whose decoded byte is a safe URI character; any other
// escape passes through literally and its two bytes are re-examined.
// ----------------------------------------------------------------------------
//
//  channel | dir | word        | fields
//  --------+-----+-------------+--------------------------------
//  enc     | in  | in_word_t   | in_byte[7:0], in_last
//  dec     | out | out_word_t  | out_byte[7:0], run_end, text_end
//
//  An accepted byte is decoded in the cycle of acceptance and its 0 to 3
//  result words land in a three-entry result register. Words drain one per
//  cycle while dec.ready holds, so ordinary text then flows at one byte per
//  cycle. enc.ready falls while the result register has more than one word
//  left, or when the last word is stalled by dec.ready. Reset (rst,
//  synchronous) clears the escape state and empties the result register.
//
module uri_percent_decoder_safe (
  input  logic                 clk,
  input  logic                 rst,
  upd_stream_if.sink           enc,
  upd_stream_if.source         dec
);

  // Escape state carried between input bytes
  logic [1:0] held_count;
  logic [7:0] held_digit;

  // Result register: up to three words from one input byte
  logic [7:0] res_byte [3];
  logic [1:0] res_count;
  logic [1:0] res_pos;
  logic       res_last;
  logic       res_valid;

  // Decode of the byte on the input channel
  logic [7:0] slot [3];
  logic [1:0] slot_count;
  logic [1:0] held_count_next;
  logic [7:0] held_digit_next;
  logic [7:0] cand [5];
  logic [4:0] cand_en;
  logic [7:0] decoded;
  logic [7:0] cur_byte;
  logic       cur_last;

  logic pos_is_end;
  logic drain_done;
  logic accept;

  assign cur_byte = enc.data.in_byte;
  assign cur_last = enc.data.in_last;
  assign decoded  = {upd_pkg::hex_value(held_digit), upd_pkg::hex_value(cur_byte)};

  // Candidate words in emission order:
  //   0 plain byte, decoded byte or literal '%'
  //   1 the held digit re-fed as text
  //   2 the current byte re-fed as text
  //   3 literal '%' flushed at end of string
  //   4 held digit flushed at end of string
  always_comb begin
    cand_en         = '0;
    cand[0]         = cur_byte;
    cand[1]         = held_digit;
    cand[2]         = cur_byte;
    cand[3]         = upd_pkg::PCT_CHAR;
    cand[4]         = 8'd0;
    held_count_next = held_count;
    held_digit_next = held_digit;
    case (held_count)
      upd_pkg::HELD_NONE: begin
        if (cur_byte == upd_pkg::PCT_CHAR) begin
          held_count_next = upd_pkg::HELD_PCT;
        end else begin
          cand_en[0] = 1'b1;
        end
      end
      upd_pkg::HELD_PCT: begin
        held_count_next = upd_pkg::HELD_TWO;
        held_digit_next = cur_byte;
      end
      default: begin
        // Complete escape: replace it, or drop back to literal text
        held_count_next = upd_pkg::HELD_NONE;
        held_digit_next = 8'd0;
        cand_en[0]      = 1'b1;
        if (upd_pkg::is_safe(decoded)) begin
          cand[0] = decoded;
        end else begin
          cand[0] = upd_pkg::PCT_CHAR;
          if (held_digit == upd_pkg::PCT_CHAR) begin
            // The first digit opens a new escape and takes this byte
            held_count_next = upd_pkg::HELD_TWO;
            held_digit_next = cur_byte;
          end else begin
            cand_en[1] = 1'b1;
            if (cur_byte == upd_pkg::PCT_CHAR) begin
              held_count_next = upd_pkg::HELD_PCT;
            end else begin
              cand_en[2] = 1'b1;
            end
          end
        end
      end
    endcase
    // End of string: flush anything held literally
    cand[4] = held_digit_next;
    if (cur_last) begin
      cand_en[3]      = (held_count_next != upd_pkg::HELD_NONE);
      cand_en[4]      = (held_count_next == upd_pkg::HELD_TWO) ||
                        (held_count_next == upd_pkg::HELD_RSVD);
      held_count_next = upd_pkg::HELD_NONE;
      held_digit_next = 8'd0;
    end
  end

  // Pack enabled candidates into the result slots
  always_comb begin
    slot_count = 2'd0;
    slot[0]    = 8'd0;
    slot[1]    = 8'd0;
    slot[2]    = 8'd0;
    for (int i = 0; i < 5; i++) begin
      if (cand_en[i] && slot_count != 2'd3) begin
        slot[slot_count] = cand[i];
        slot_count       = slot_count + 2'd1;
      end
    end
  end

  // Take a new byte once the last pending word leaves
  assign pos_is_end = (res_pos == res_count - 2'd1);
  assign drain_done = res_valid && dec.ready && pos_is_end;
  assign enc.ready  = !res_valid || drain_done;
  assign accept     = enc.valid && enc.ready;

  assign dec.valid         = res_valid;
  assign dec.data.out_byte = res_byte[res_pos];
  assign dec.data.run_end  = pos_is_end;
  assign dec.data.text_end = pos_is_end && res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= upd_pkg::HELD_NONE;
      held_digit <= 8'd0;
      res_valid  <= 1'b0;
      res_pos    <= 2'd0;
      res_count  <= 2'd1;
    end else begin
      if (accept) begin
        held_count <= held_count_next;
        held_digit <= held_digit_next;
      end
      if (accept && slot_count != 2'd0) begin
        // Load the new group of words
        res_valid <= 1'b1;
        res_pos   <= 2'd0;
        res_count <= slot_count;
      end else if (drain_done) begin
        res_valid <= 1'b0;
        res_pos   <= 2'd0;
      end else if (res_valid && dec.ready) begin
        // Advance to the next word of the group
        res_pos <= res_pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && slot_count != 2'd0) begin
      res_byte[0] <= slot[0];
      res_byte[1] <= slot[1];
      res_byte[2] <= slot[2];
      res_last    <= cur_last;
    end
  end

  // Pending group is never empty and the read position stays inside it
  a_res_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_count != 2'd0) && (res_pos < res_count))
    else $error("result register position outside its group");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held_count != upd_pkg::HELD_RSVD)
    else $error("escape state took the unused code");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && cur_last |=> (held_count == upd_pkg::HELD_NONE) && (held_digit == 8'd0))
    else $error("escape state not cleared at end of string");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    accept && cur_last |=> res_valid && res_last)
    else $error("end of string gave no final word");

endmodule
